// File: sv/bias_stability_qualifier_defines.svh
// Assertion macros shared by the bias stability qualifier RTL.
// Depends on nothing; the including module supplies clk and rst_n.
`ifndef BIAS_STABILITY_QUALIFIER_DEFINES_SVH
`define BIAS_STABILITY_QUALIFIER_DEFINES_SVH

// Check a property on every rising edge outside of reset.
`define BSQ_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a property on every rising edge, reset included.
`define BSQ_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: sv/bsq_pkg.sv
// Shared types and constants of the bias stability qualifier.
// Depends on nothing; imported by every module of the block.
package bsq_pkg;

    localparam int AXES     = 3;
    localparam int TIME_W   = 48;
    localparam int BIAS_W   = 32;
    localparam int VAR_W    = 32;
    localparam int LIMIT_W  = 31;
    localparam int RATIO_W  = 16;
    localparam int NEED_W   = 32;
    localparam int SQ_W     = 2 * LIMIT_W;
    localparam int SUM_W    = SQ_W + 2;
    localparam int SCALED_W = SUM_W + 7;
    localparam int PROD_W   = RATIO_W + VAR_W;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_VAR_CEILING   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RATIO_LIMIT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STABLE_NEEDED = 2'd2;

    localparam logic [VAR_W-1:0]   VAR_CEILING_RST   = 32'd4294967;
    localparam logic [RATIO_W-1:0] RATIO_LIMIT_RST   = 16'd100;
    localparam logic [NEED_W-1:0]  STABLE_NEEDED_RST = 32'd10000000;

    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

    // Step strobes that the sequencer hands to lanes and merge unit
    typedef struct packed {
        logic diff;
        logic square;
    } step_t;

    typedef struct packed {
        logic [TIME_W-1:0]                time_us;
        logic [AXES-1:0][BIAS_W-1:0]      bias;
        logic [AXES-1:0][VAR_W-1:0]       variance;
        logic [LIMIT_W-1:0]               drift_limit;
        logic                             estimate_ok;
        logic                             learning_ok;
        logic                             takeoff_edge;
    } item_t;

endpackage

// File: sv/bsq_lane.sv
// One axis lane: distance from the reference bias, limit check and square.
// Depends on bsq_pkg.
module bsq_lane
    import bsq_pkg::*;
(
    input  logic               clk,
    input  step_t              step,
    input  logic [BIAS_W-1:0]  ref_bias,
    input  logic [BIAS_W-1:0]  bias,
    input  logic [LIMIT_W-1:0] drift_limit,
    output logic               over,
    output logic [SQ_W-1:0]    sq
);

    logic [BIAS_W:0]    diff;
    logic [BIAS_W:0]    mag;
    logic               over_reg;
    logic [LIMIT_W-1:0] mag_reg;
    logic [SQ_W-1:0]    sq_reg;

    always_comb
    begin
        diff = {ref_bias[BIAS_W-1], ref_bias} - {bias[BIAS_W-1], bias};
        mag  = diff[BIAS_W] ? (~diff + {{BIAS_W{1'b0}}, 1'b1}) : diff;
    end

    always_ff @(posedge clk)
    begin
        if (step.diff)
        begin
            over_reg <= (mag > {2'b00, drift_limit});
            mag_reg  <= mag[LIMIT_W-1:0];
        end
        // magnitude is below 2^31 whenever the square matters
        if (step.square)
        begin
            sq_reg <= SQ_W'(mag_reg) * SQ_W'(mag_reg);
        end
    end

    assign over = over_reg;
    assign sq   = sq_reg;

endmodule

// File: sv/bsq_merge.sv
// Merge unit: combines the lane results and checks the variance spread.
// Depends on bsq_pkg; fed by the bsq_lane instances.
module bsq_merge
    import bsq_pkg::*;
(
    input  logic                        clk,
    input  step_t                       step,
    input  logic [AXES-1:0][VAR_W-1:0]  variance,
    input  logic [LIMIT_W-1:0]          drift_limit,
    input  logic                        estimate_ok,
    input  logic [VAR_W-1:0]            var_ceiling,
    input  logic [RATIO_W-1:0]          ratio_limit,
    input  logic [AXES-1:0]             lane_over,
    input  logic [AXES-1:0][SQ_W-1:0]   lane_sq,
    output logic                        est_valid,
    output logic                        moved
);

    logic [VAR_W-1:0]    vmax;
    logic [VAR_W-1:0]    vmin;
    logic [VAR_W-1:0]    vmax_reg;
    logic [VAR_W-1:0]    vmin_reg;
    logic [SQ_W-1:0]     limsq_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic [SUM_W-1:0]    sum;
    logic [SCALED_W-1:0] scaled;

    always_comb
    begin
        vmax = variance[0];
        vmin = variance[0];
        for (int i = 1; i < AXES; i++)
        begin
            if (variance[i] > vmax)
                vmax = variance[i];
            if (variance[i] < vmin)
                vmin = variance[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (step.diff)
        begin
            vmax_reg  <= vmax;
            vmin_reg  <= vmin;
            limsq_reg <= SQ_W'(drift_limit) * SQ_W'(drift_limit);
        end
        if (step.square)
        begin
            prod_reg <= PROD_W'(ratio_limit) * PROD_W'(vmin_reg);
        end
    end

    // 100 * sum > limit^2 is the exact form of |d| > limit / 10
    always_comb
    begin
        sum = '0;
        for (int i = 0; i < AXES; i++)
            sum = sum + SUM_W'(lane_sq[i]);
        scaled = {1'b0, sum, 6'b0} + {2'b0, sum, 5'b0} + {5'b0, sum, 2'b0};
    end

    assign moved     = (|lane_over) || (scaled > SCALED_W'(limsq_reg));
    assign est_valid = estimate_ok && (vmax_reg < var_ceiling)
                       && (PROD_W'(vmax_reg) < prod_reg);

endmodule

// File: sv/bias_stability_qualifier.sv
// Top level of the bias stability qualifier: buffers, sequencer, record state.
// Depends on bsq_pkg, bsq_lane, bsq_merge and bias_stability_qualifier_defines.svh.
//
//   channel   | dir | handshake           | payload
//   ----------+-----+---------------------+-----------------------------------------
//   s_*       | in  | s_tvalid / s_tready | s_tdata (272b), s_tuser (3b) one request
//   m_*       | out | m_tvalid / m_tready | m_tdata (144b), m_tuser (1b) one result
//   cfg_*     | in  | cfg_valid/cfg_ready | cfg_index (2b), cfg_data (32b)
//
// Each request passes through the core steps in order (clear, lane diff, lane square,
// merge); the next one starts only after the previous one's merge, as every request
// depends on the record the previous one leaves. A one-entry input buffer takes the
// next request while the core works and an output register holds the result.
// The merge step waits while the output register is full and not taken.
// Reset clears the record and loads the register defaults; no clearing pass.
`include "bias_stability_qualifier_defines.svh"

module bias_stability_qualifier
    import bsq_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // time_us[47:0], bias_x[79:48], bias_y[111:80], bias_z[143:112],
    // variance_x[175:144], variance_y[207:176], variance_z[239:208],
    // drift limit[270:240], zero pad[271]
    input  logic [271:0]          s_tdata,
    // estimate_ok[0], learning_ok[1], takeoff_edge[2]
    input  logic [2:0]            s_tuser,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // kept_bias_x[31:0], kept_bias_y[63:32], kept_bias_z[95:64],
    // stable_time[143:96]
    output logic [143:0]          m_tdata,
    // cal_ready[0]
    output logic [0:0]            m_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_CLEAR  = 5'b00010,
        ST_DIFF   = 5'b00100,
        ST_SQUARE = 5'b01000,
        ST_MERGE  = 5'b10000
    } core_state_t;

    core_state_t state_reg, state_next;

    logic [VAR_W-1:0]   var_ceiling_reg;
    logic [RATIO_W-1:0] ratio_limit_reg;
    logic [NEED_W-1:0]  stable_needed_reg;

    logic  buf_valid_reg;
    item_t buf_item_reg;
    item_t item_reg;

    // record state
    logic [AXES-1:0][BIAS_W-1:0] ref_reg, ref_next;
    logic [TIME_W-1:0]           accum_reg, accum_next;
    logic [TIME_W-1:0]           prev_time_reg, prev_time_next;
    logic                        prev_valid_reg, prev_valid_next;
    logic                        ready_reg, ready_next;

    logic [TIME_W-1:0] el_reg;
    logic [TIME_W-1:0] acc_eff_reg;
    logic              gt_reg;
    logic [TIME_W:0]   acc_sum;
    logic [TIME_W-1:0] acc_sat;
    logic [TIME_W-1:0] acc_eff;

    logic               m_tvalid_reg;
    logic [143:0]       m_tdata_reg;
    logic               m_tuser_reg;

    step_t                     step;
    logic [AXES-1:0]           lane_over;
    logic [AXES-1:0][SQ_W-1:0] lane_sq;
    logic                      est_valid;
    logic                      moved;
    logic                      out_free;
    logic                      merge_fire;
    logic                      start;

    // ---------------------------------------------------------------
    // Configuration: always ready, index beyond the list is dropped
    // ---------------------------------------------------------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            var_ceiling_reg   <= VAR_CEILING_RST;
            ratio_limit_reg   <= RATIO_LIMIT_RST;
            stable_needed_reg <= STABLE_NEEDED_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_VAR_CEILING:   var_ceiling_reg   <= cfg_data[VAR_W-1:0];
                REG_RATIO_LIMIT:   ratio_limit_reg   <= cfg_data[RATIO_W-1:0];
                REG_STABLE_NEEDED: stable_needed_reg <= cfg_data[NEED_W-1:0];
                default:           ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Input buffer and core hand-off
    // ---------------------------------------------------------------
    assign s_tready   = !buf_valid_reg;
    assign out_free   = !m_tvalid_reg || m_tready;
    assign merge_fire = (state_reg == ST_MERGE) && out_free;
    assign start      = buf_valid_reg && ((state_reg == ST_IDLE) || merge_fire);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            buf_valid_reg <= 1'b0;
        else if (s_tvalid && s_tready)
            buf_valid_reg <= 1'b1;
        else if (start)
            buf_valid_reg <= 1'b0;
    end

    // Unpack the request into its fields on acceptance
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            buf_item_reg.time_us      <= s_tdata[47:0];
            buf_item_reg.bias[0]      <= s_tdata[79:48];
            buf_item_reg.bias[1]      <= s_tdata[111:80];
            buf_item_reg.bias[2]      <= s_tdata[143:112];
            buf_item_reg.variance[0]  <= s_tdata[175:144];
            buf_item_reg.variance[1]  <= s_tdata[207:176];
            buf_item_reg.variance[2]  <= s_tdata[239:208];
            buf_item_reg.drift_limit  <= s_tdata[270:240];
            buf_item_reg.estimate_ok  <= s_tuser[0];
            buf_item_reg.learning_ok  <= s_tuser[1];
            buf_item_reg.takeoff_edge <= s_tuser[2];
        end
        if (start)
            item_reg <= buf_item_reg;
    end

    // ---------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (start) state_next = ST_CLEAR;
            ST_CLEAR:  state_next = ST_DIFF;
            ST_DIFF:   state_next = ST_SQUARE;
            ST_SQUARE: state_next = ST_MERGE;
            ST_MERGE:
            begin
                if (merge_fire)
                    state_next = start ? ST_CLEAR : ST_IDLE;
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    assign step.diff   = (state_reg == ST_DIFF);
    assign step.square = (state_reg == ST_SQUARE);

    // ---------------------------------------------------------------
    // Lanes, one per axis, and the merge unit
    // ---------------------------------------------------------------
    for (genvar g = 0; g < AXES; g++)
    begin : g_lane
        bsq_lane u_lane (
            .clk         (clk),
            .step        (step),
            .ref_bias    (ref_reg[g]),
            .bias        (item_reg.bias[g]),
            .drift_limit (item_reg.drift_limit),
            .over        (lane_over[g]),
            .sq          (lane_sq[g])
        );
    end

    bsq_merge u_merge (
        .clk         (clk),
        .step        (step),
        .variance    (item_reg.variance),
        .drift_limit (item_reg.drift_limit),
        .estimate_ok (item_reg.estimate_ok),
        .var_ceiling (var_ceiling_reg),
        .ratio_limit (ratio_limit_reg),
        .lane_over   (lane_over),
        .lane_sq     (lane_sq),
        .est_valid   (est_valid),
        .moved       (moved)
    );

    // ---------------------------------------------------------------
    // Elapsed time and saturating accumulation, ahead of the merge
    // ---------------------------------------------------------------
    always_comb
    begin
        acc_sum = {1'b0, accum_reg} + {1'b0, el_reg};
        acc_sat = acc_sum[TIME_W] ? TIME_MAX : acc_sum[TIME_W-1:0];
        acc_eff = prev_valid_reg ? acc_sat : accum_reg;
    end

    always_ff @(posedge clk)
    begin
        // elapsed time wraps modulo 2^48 when the clock runs backwards
        if (step.diff)
            el_reg <= item_reg.time_us - prev_time_reg;
        if (step.square)
        begin
            acc_eff_reg <= acc_eff;
            gt_reg      <= (acc_eff > TIME_W'(stable_needed_reg));
        end
    end

    // ---------------------------------------------------------------
    // Record update: takeoff clear in the clear step, decision at merge
    // ---------------------------------------------------------------
    always_comb
    begin
        ref_next        = ref_reg;
        accum_next      = accum_reg;
        prev_time_next  = prev_time_reg;
        prev_valid_next = prev_valid_reg;
        ready_next      = ready_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (item_reg.takeoff_edge)
                begin
                    ref_next        = '0;
                    accum_next      = '0;
                    prev_time_next  = '0;
                    prev_valid_next = 1'b0;
                    ready_next      = 1'b0;
                end
            end
            ST_MERGE:
            begin
                if (merge_fire)
                begin
                    if (est_valid && item_reg.learning_ok)
                    begin
                        if (!moved)
                        begin
                            accum_next = acc_eff_reg;
                            if (gt_reg)
                                ready_next = 1'b1;
                        end
                        else
                        begin
                            // bias drifted: restart from the new estimate
                            accum_next = '0;
                            ref_next   = item_reg.bias;
                            ready_next = 1'b0;
                        end
                        prev_time_next  = item_reg.time_us;
                        prev_valid_next = 1'b1;
                    end
                    else
                    begin
                        prev_time_next  = '0;
                        prev_valid_next = 1'b0;
                        // invalid estimate drops any record built so far
                        if (!est_valid && (accum_reg != '0))
                        begin
                            ref_next   = '0;
                            accum_next = '0;
                            ready_next = 1'b0;
                        end
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_reg        <= '0;
            accum_reg      <= '0;
            prev_time_reg  <= '0;
            prev_valid_reg <= 1'b0;
            ready_reg      <= 1'b0;
        end
        else
        begin
            ref_reg        <= ref_next;
            accum_reg      <= accum_next;
            prev_time_reg  <= prev_time_next;
            prev_valid_reg <= prev_valid_next;
            ready_reg      <= ready_next;
        end
    end

    // ---------------------------------------------------------------
    // Output register: hold the result until the sink takes it
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else if (merge_fire)
            m_tvalid_reg <= 1'b1;
        else if (m_tready)
            m_tvalid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (merge_fire)
        begin
            m_tdata_reg <= {accum_next, ref_next[2], ref_next[1], ref_next[0]};
            m_tuser_reg <= ready_next;
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = m_tuser_reg;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    `BSQ_ASSERT(a_ready_needs_time, ready_reg |-> (accum_reg != '0),
        "calibration ready with no stable time accumulated")
    `BSQ_ASSERT(a_idle_starts, ((state_reg == ST_IDLE) && buf_valid_reg) |=>
        (state_reg == ST_CLEAR), "buffered request not picked up by idle core")
    `BSQ_ASSERT(a_merge_exit, merge_fire |=>
        ((state_reg == ST_CLEAR) || (state_reg == ST_IDLE)), "bad state after merge")
    `BSQ_ASSERT(a_result_from_merge, $rose(m_tvalid_reg) |-> $past(merge_fire),
        "result shown without a merge step")

endmodule

// File: dv/testbench.sv
// Self-checking testbench of bias_stability_qualifier: stream stimulus, register writes
// and a scoreboard that predicts every result. Depends on bsq_pkg and the block's RTL.
module testbench;
    import bsq_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 500000;
    localparam int unsigned DRAIN_CYCLES = 16;
    // Index past the last register: the block ignores writes to it
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    // One result as it leaves the block, {m_tuser, m_tdata}
    typedef struct packed {
        logic              cal_ready;
        logic [TIME_W-1:0] stable_time;
        logic [BIAS_W-1:0] kept_z;
        logic [BIAS_W-1:0] kept_y;
        logic [BIAS_W-1:0] kept_x;
    } record_t;

    // Scoreboard: holds its own copy of the stored record and the registers,
    // predicts the result of each accepted request and checks results in order.
    class bias_record_checker;
        logic [VAR_W-1:0]            var_ceiling;
        logic [RATIO_W-1:0]          ratio_limit;
        logic [NEED_W-1:0]           time_needed;
        logic [AXES-1:0][BIAS_W-1:0] kept;
        logic [TIME_W-1:0]           accum;
        logic [TIME_W-1:0]           last_time;
        bit                          last_valid;
        bit                          ready;
        record_t                     expected_records[$];
        int unsigned                 failures;

        function new();
            var_ceiling = VAR_CEILING_RST;
            ratio_limit = RATIO_LIMIT_RST;
            time_needed = STABLE_NEEDED_RST;
            failures    = 0;
            clear_record();
        endfunction

        function void clear_record();
            kept       = '0;
            accum      = '0;
            last_time  = '0;
            last_valid = 1'b0;
            ready      = 1'b0;
        endfunction

        function void flag(string msg);
            failures++;
            if (failures <= 10)
                $display("%s", msg);
        endfunction

        function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                REG_VAR_CEILING:   var_ceiling = val;
                REG_RATIO_LIMIT:   ratio_limit = val[RATIO_W-1:0];
                REG_STABLE_NEEDED: time_needed = val;
                default: ;
            endcase
        endfunction

        // True when the new bias lies farther than a tenth of the limit from the kept one
        function bit drifted(logic [AXES-1:0][BIAS_W-1:0] b, logic [LIMIT_W-1:0] limit);
            longint          d;
            longint unsigned mag;
            longint unsigned sum;
            longint unsigned lim;
            int              i;
            sum = 0;
            lim = limit;
            for (i = 0; i < AXES; i++)
            begin
                d   = longint'($signed(kept[i])) - longint'($signed(b[i]));
                mag = (d < 0) ? -d : d;
                if (mag > lim)
                    return 1'b1;
                sum += mag * mag;
            end
            return sum > (lim * lim) / 100;
        endfunction

        function void note_request(logic [271:0] data, logic [2:0] user);
            logic [TIME_W-1:0]           t;
            logic [TIME_W-1:0]           elapsed;
            logic [TIME_W:0]             total;
            logic [AXES-1:0][BIAS_W-1:0] b;
            logic [AXES-1:0][VAR_W-1:0]  v;
            logic [VAR_W-1:0]            vmax;
            logic [VAR_W-1:0]            vmin;
            logic [LIMIT_W-1:0]          limit;
            bit                          valid;
            int                          i;
            t     = data[47:0];
            b     = data[143:48];
            v     = data[239:144];
            limit = data[270:240];
            if (user[2])
                clear_record();
            vmax = v[0];
            vmin = v[0];
            for (i = 1; i < AXES; i++)
            begin
                if (v[i] > vmax)
                    vmax = v[i];
                if (v[i] < vmin)
                    vmin = v[i];
            end
            valid = user[0] && (vmax < var_ceiling)
                    && (64'(vmax) < 64'(ratio_limit) * 64'(vmin));
            if (valid && user[1])
            begin
                if (!drifted(b, limit))
                begin
                    if (last_valid)
                    begin
                        elapsed = t - last_time;
                        total   = {1'b0, accum} + {1'b0, elapsed};
                        accum   = total[TIME_W] ? TIME_MAX : total[TIME_W-1:0];
                    end
                    if (accum > time_needed)
                        ready = 1'b1;
                end
                else
                begin
                    accum = '0;
                    kept  = b;
                    ready = 1'b0;
                end
                last_time  = t;
                last_valid = 1'b1;
            end
            else
            begin
                last_time  = '0;
                last_valid = 1'b0;
                if (!valid && accum != 0)
                    clear_record();
            end
            expected_records.push_back(record_t'({ready, accum, kept}));
        endfunction

        function void check_result(logic [143:0] data, logic [0:0] user);
            record_t want;
            record_t got;
            got = {user, data};
            if (expected_records.size() == 0)
            begin
                flag($sformatf("result with no request pending: %h", got));
                return;
            end
            want = expected_records.pop_front();
            if (got !== want)
                flag($sformatf({"mismatch (expected/actual): cal_ready %0d/%0d ",
                                "stable_time %0d/%0d kept_x %h/%h kept_y %h/%h kept_z %h/%h"},
                               want.cal_ready, got.cal_ready, want.stable_time,
                               got.stable_time, want.kept_x, got.kept_x, want.kept_y,
                               got.kept_y, want.kept_z, got.kept_z));
        endfunction

        function int unsigned pending_count();
            return expected_records.size();
        endfunction
    endclass

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic [271:0]          s_tdata   = '0;
    logic [2:0]            s_tuser   = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [143:0]          m_tdata;
    logic [0:0]            m_tuser;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    bias_record_checker qualifier_check = new();

    // Stimulus state: the current well-formed run and the registers last written
    logic [TIME_W-1:0]           run_time;
    logic [AXES-1:0][BIAS_W-1:0] run_center;
    logic [LIMIT_W-1:0]          run_limit;
    logic [VAR_W-1:0]            cur_ceiling;
    logic [RATIO_W-1:0]          cur_ratio;
    bit                          source_quiet = 1'b0;
    bit                          sink_quiet   = 1'b0;
    int unsigned                 sink_hold    = 0;
    int unsigned                 cycle_count  = 0;

    always #5 clk = ~clk;

    bias_stability_qualifier dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Mostly short idle stretches, now and then a long one
    function automatic int unsigned idle_len(bit quiet);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Watch both handshakes and the register channel at every edge; values read
    // here are the ones the block saw. Then pick the next sink stall.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("bias_stability_qualifier regression: fail");
            $finish;
        end
        else
        begin
            if (rst_n)
            begin
                if (s_tvalid && s_tready)
                    qualifier_check.note_request(s_tdata, s_tuser);
                if (m_tvalid && m_tready)
                    qualifier_check.check_result(m_tdata, m_tuser);
                if (cfg_valid && cfg_ready)
                    qualifier_check.write_register(cfg_index, cfg_data);
            end
            if (sink_hold == 0 && !sink_quiet && $urandom_range(0, 3) == 0)
                sink_hold = idle_len(1'b0);
            if (sink_hold != 0)
            begin
                sink_hold--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // Offer one request and hold it until taken; drop valid only when a gap follows,
    // so back-to-back requests keep valid high without a glitch.
    task automatic send_item(input logic [TIME_W-1:0] t,
                             input logic [AXES-1:0][BIAS_W-1:0] b,
                             input logic [AXES-1:0][VAR_W-1:0] v,
                             input logic [LIMIT_W-1:0] lim,
                             input bit eok, input bit lok, input bit tko);
        int unsigned gap;
        s_tdata  <= {1'b0, lim, v, b, t};
        s_tuser  <= {tko, lok, eok};
        s_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        gap = idle_len(source_quiet);
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Stop sending and wait until every pending result is out, then let the
    // core run dry before anything touches the registers.
    task automatic settle();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (qualifier_check.pending_count() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Write all three registers back to back, sometimes plus the unused index.
    // Junk in the upper half of the ratio write must be dropped by the block.
    task automatic program_registers(input logic [VAR_W-1:0] ceil,
                                     input logic [RATIO_W-1:0] ratio,
                                     input logic [NEED_W-1:0] needed);
        logic [CFG_IDX_W-1:0]  idx[4];
        logic [CFG_DATA_W-1:0] val[4];
        int                    n;
        int                    i;
        idx = '{REG_VAR_CEILING, REG_RATIO_LIMIT, REG_STABLE_NEEDED, REG_UNUSED};
        val = '{ceil, {16'($urandom), ratio}, needed, $urandom};
        n   = $urandom_range(0, 1) ? 4 : 3;
        for (i = 0; i < n; i++)
        begin
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            cfg_valid <= 1'b1;
            do
                @(posedge clk);
            while (!cfg_ready);
        end
        cfg_valid   <= 1'b0;
        cur_ceiling = ceil;
        cur_ratio   = ratio;
    endtask

    // Corner cases under the reset register values: zero and boundary variances,
    // exact tenth-of-limit distance, time zero, time running backwards, accumulator
    // saturation, learning inhibited, invalid estimate clearing, takeoff, extremes.
    task automatic directed_items();
        logic [AXES-1:0][VAR_W-1:0]  vok;
        logic [AXES-1:0][BIAS_W-1:0] zero_b;
        logic [AXES-1:0][BIAS_W-1:0] kept_b;
        vok    = {3{32'd1000}};
        zero_b = '0;
        kept_b = {32'd0, 32'd1001, 32'd1};
        send_item(48'd0, zero_b, '0, 31'd0, 1, 1, 0);
        send_item(48'd0, zero_b, vok, 31'd0, 1, 1, 0);
        send_item(48'd5000, zero_b, vok, 31'd0, 1, 1, 0);
        send_item(48'd10_005_001, zero_b, vok, 31'd0, 1, 1, 0);
        send_item(48'd10_005_101, {32'd0, 32'd0, 32'd1}, vok, 31'd0, 1, 1, 0);
        send_item(48'd10_005_201, {32'd0, 32'd0, 32'd1001}, vok, 31'd10000, 1, 1, 0);
        send_item(48'd10_005_301, kept_b, vok, 31'd10000, 1, 1, 0);
        send_item(48'd50, kept_b, vok, 31'd0, 1, 1, 0);
        send_item(48'd40, kept_b, vok, 31'd0, 1, 1, 0);
        send_item(48'd1000, kept_b, vok, 31'd0, 1, 0, 0);
        send_item(48'd2000, kept_b, vok, 31'd0, 1, 1, 0);
        send_item(48'd3000, kept_b, vok, 31'd0, 0, 1, 0);
        send_item(48'd4000, kept_b, vok, 31'd0, 0, 1, 0);
        send_item(48'd5000, zero_b, {32'd4294966, 32'd4294966, 32'd4294967}, 31'd0, 1, 1, 0);
        send_item(48'd6000, zero_b, {3{32'd4294966}}, 31'd0, 1, 1, 0);
        send_item(48'd6010, zero_b, {3{32'd4294966}}, 31'd0, 1, 1, 0);
        send_item(48'd6020, zero_b, {32'd50000, 32'd100000, 32'd1000}, 31'd0, 1, 1, 0);
        send_item(48'd6030, zero_b, {32'd50000, 32'd99999, 32'd1000}, 31'd0, 1, 1, 0);
        send_item(48'd6040, {3{32'h8000_0000}}, vok, 31'h7FFF_FFFF, 1, 1, 0);
        send_item(48'd6050, {3{32'h7FFF_FFFF}}, vok, 31'h7FFF_FFFF, 1, 1, 0);
        send_item(48'd6060, {3{32'h7FFF_FFFF}}, vok, 31'h7FFF_FFFF, 1, 1, 1);
        send_item(TIME_MAX, {3{32'hFFFF_FFFF}}, {3{32'hFFFF_FFFF}}, 31'h7FFF_FFFF, 1, 1, 1);
        send_item(48'd0, zero_b, '0, 31'd0, 0, 0, 0);
    endtask

    // Mostly well-formed runs: time moving forward, bias wandering inside a tenth
    // of the limit, variances that pass both tests. The rest starts new runs,
    // breaks one condition, or is pure noise over every bit.
    task automatic send_random_item();
        int unsigned                 pick;
        int unsigned                 step_kind;
        int unsigned                 axis;
        logic [TIME_W-1:0]           t;
        logic [AXES-1:0][BIAS_W-1:0] b;
        logic [AXES-1:0][VAR_W-1:0]  v;
        logic [VAR_W-1:0]            hi;
        logic [VAR_W-1:0]            base;
        logic [VAR_W-1:0]            spread;
        logic [BIAS_W-1:0]           span;
        bit                          lok;
        bit                          tko;
        int                          i;
        pick = $urandom_range(0, 99);
        if (pick >= 95)
        begin
            t = {16'($urandom), 32'($urandom)};
            b = {32'($urandom), 32'($urandom), 32'($urandom)};
            v = {32'($urandom), 32'($urandom), 32'($urandom)};
            send_item(t, b, v, 31'($urandom), $urandom_range(0, 1), $urandom_range(0, 1),
                      $urandom_range(0, 1));
        end
        else
        begin
            if (pick >= 89)
            begin
                for (i = 0; i < AXES; i++)
                    run_center[i] = 32'($urandom_range(0, 32'h7FFF_FFFF)) - 32'h4000_0000;
                if ($urandom_range(0, 3) == 0)
                    run_limit = '0;
                else
                    run_limit = 31'($urandom_range(1, 32'h3FFF_FFFF) >> $urandom_range(0, 20));
            end
            // advance time: mostly moderate steps, some long, a few tiny
            step_kind = $urandom_range(0, 9);
            if (step_kind < 7)
                run_time += $urandom_range(1, 200000);
            else if (step_kind < 9)
                run_time += $urandom_range(200000, 5000000);
            else
                run_time += $urandom_range(0, 5);
            t    = run_time;
            span = 32'(run_limit / 20);
            for (i = 0; i < AXES; i++)
                b[i] = run_center[i] + 32'($urandom_range(0, 2 * span)) - span;
            hi = cur_ceiling >> 1;
            if (hi == 0)
                hi = 1;
            base = 32'($urandom_range(1, hi)) >> $urandom_range(0, 24);
            if (base == 0)
                base = 1;
            spread = (cur_ratio >= 2) ? (base >> 1) : '0;
            for (i = 0; i < AXES; i++)
                v[i] = base + 32'($urandom_range(0, spread));
            lok = ($urandom_range(0, 19) != 0);
            tko = ($urandom_range(0, 39) == 0);
            axis = $urandom_range(0, AXES - 1);
            if (pick >= 82 && pick < 89)
            begin
                case ($urandom_range(0, 4))
                    0: ;
                    1: v[axis] = cur_ceiling + 32'($urandom_range(0, 1000));
                    2: v[axis] = '0;
                    3: b[axis] = b[axis] + 32'(run_limit / 5) + 32'($urandom_range(1, 1000));
                    default:
                    begin
                        run_time = run_time - $urandom_range(1, 100000);
                        t        = run_time;
                    end
                endcase
                // here estimate_ok follows the low bit of pick, whichever case was taken above
                send_item(t, b, v, run_limit, pick[0], lok, tko);
            end
            else
                send_item(t, b, v, run_limit, 1'b1, lok, tko);
        end
    endtask

    // Run a batch of random requests; reshuffle the no-idle stretches now and then
    task automatic run_phase(input int unsigned count);
        int unsigned i;
        for (i = 0; i < count; i++)
        begin
            if (i % 40 == 0)
            begin
                source_quiet = ($urandom_range(0, 3) == 0);
                sink_quiet   = ($urandom_range(0, 3) == 0);
            end
            send_random_item();
        end
    endtask

    initial
    begin
        run_time    = '0;
        run_center  = '0;
        run_limit   = 31'd100000;
        cur_ceiling = VAR_CEILING_RST;
        cur_ratio   = RATIO_LIMIT_RST;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // reset values first, with the corner cases that depend on them
        program_registers(VAR_CEILING_RST, RATIO_LIMIT_RST, STABLE_NEEDED_RST);
        directed_items();
        settle();

        // widest acceptance, calibration ready once any stable time accumulates
        program_registers(32'hFFFF_FFFF, 16'hFFFF, 32'd0);
        run_phase(150);
        settle();

        // nothing can be valid: zero ceiling, ratio of one, longest wait
        program_registers(32'd0, 16'd1, 32'hFFFF_FFFF);
        run_phase(40);
        settle();

        // zero ratio register rejects every estimate
        program_registers(32'd50_000_000, 16'd0, 32'd1000);
        run_phase(40);
        settle();

        // reset values again; hold off the sender once until the block drains
        program_registers(VAR_CEILING_RST, RATIO_LIMIT_RST, STABLE_NEEDED_RST);
        run_phase(170);
        settle();
        run_phase(100);
        settle();

        program_registers(32'($urandom_range(1000, 32'hFFFF_FFFF)),
                          16'($urandom_range(2, 1000)), 32'd200000);
        run_phase(200);
        settle();

        program_registers(32'($urandom), 16'($urandom_range(1, 16'hFFFF)),
                          32'($urandom_range(0, 5000000)));
        run_phase(150);
        settle();

        if (qualifier_check.failures == 0)
            $display("bias_stability_qualifier regression: pass");
        else
            $display("bias_stability_qualifier regression: fail");
        $finish;
    end
endmodule
